// ===== rtl/tpdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpdq_pkg
// Shared types and constants of the timed packet delay queue.
// ----------------------------------------------------------------------------
package tpdq_pkg;

  localparam int DEF_QUEUE_DEPTH = 32;
  localparam int DEF_TAG_BITS    = 16;

  localparam int TAG_FIELD_W = 16;
  localparam int NOW_W       = 32;
  localparam int DELAY_W     = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [DELAY_W-1:0] DELAY_MAX   = 13'd5000;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 13'd100;

  localparam logic [1:0] MODE_PACKET = 2'd0;
  localparam logic [1:0] MODE_TICK   = 2'd1;
  localparam logic [1:0] MODE_FLUSH  = 2'd2;

  localparam logic [1:0] DISP_RELEASED = 2'd0;
  localparam logic [1:0] DISP_PASSED   = 2'd1;
  localparam logic [1:0] DISP_REFUSED  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_IN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_OUT = 2'd2;

  typedef struct packed {
    logic [1:0]             mode;
    logic [TAG_FIELD_W-1:0] packet_tag;
    logic                   is_outbound;
    logic [NOW_W-1:0]       now_ms;
  } in_item_t;

  typedef struct packed {
    logic [TAG_FIELD_W-1:0] tag_out;
    logic [1:0]             disposition;
    logic                   last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK
  } state_t;

endpackage

// ===== rtl/timed_packet_delay_queue.sv =====
`timescale 1ns / 1ps
// A passed or refused packet is put on the result port after the due check of its
// transfer; a released entry after the check that follows the one that pops it.
// Each item takes one memory read and one due check of the head entry, plus one more
// read and check per released entry; a flush leaves the block in idle. A new item is
// taken only in idle; output stalls hold the check. Synchronous active-high reset empties
// the queue and loads delay 100 ms with both capture directions on; no memory clearing pass.
// ----------------------------------------------------------------------------
// timed_packet_delay_queue
// Fixed-delay timestamp FIFO: queues packet tags until their release time.
// ----------------------------------------------------------------------------
module timed_packet_delay_queue
  import tpdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TAG_BITS    = DEF_TAG_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  in_item_t              item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output out_item_t             result
);

  localparam int TW = (TAG_BITS < TAG_FIELD_W) ? TAG_BITS : TAG_FIELD_W;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int OW = $clog2(QUEUE_DEPTH + 1);
  localparam int MW = TW + NOW_W;
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [OW-1:0] OCC_FULL = OW'(QUEUE_DEPTH);

  state_t state, state_next;

  logic [DELAY_W-1:0] delay_ms;
  logic               capture_inbound;
  logic               capture_outbound;

  logic [PW-1:0] rp, wp;
  logic [OW-1:0] occ;
  logic [NOW_W-1:0] cur_now;

  logic [TAG_FIELD_W-1:0] pend_tag;
  logic [1:0]             pend_disp;
  logic                   pend_v;

  logic          accept;
  logic          capture;
  logic          wr_en;
  logic [MW-1:0] wr_data;
  logic [MW-1:0] rd_data;
  logic [TW-1:0]    rd_tag;
  logic [NOW_W-1:0] rd_rel;
  logic [NOW_W-1:0] diff;
  logic          head_due;
  logic          res_free;
  logic          pop;
  logic          emit;
  logic          emit_last;

  assign accept   = item_valid && !item_stall;
  assign capture  = item.is_outbound ? capture_outbound : capture_inbound;
  assign wr_en    = accept && (item.mode == MODE_PACKET) && capture && (occ != OCC_FULL);
  assign wr_data  = {item.packet_tag[TW-1:0], item.now_ms + NOW_W'(delay_ms)};
  assign rd_tag   = rd_data[MW-1:NOW_W];
  assign rd_rel   = rd_data[NOW_W-1:0];
  assign diff     = cur_now - rd_rel;
  assign head_due = (occ != '0) && !diff[NOW_W-1];
  assign res_free = !result_valid || !result_stall;

  tpdq_store #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (MW),
    .AW    (PW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wp),
    .wr_data (wr_data),
    .rd_addr (rp),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (item.mode != MODE_FLUSH)) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_CHECK;
      ST_CHECK: begin
        if (!pend_v || res_free) begin
          state_next = head_due ? ST_READ : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    item_stall = 1'b1;
    pop        = 1'b0;
    emit       = 1'b0;
    emit_last  = 1'b0;
    unique case (state)
      ST_IDLE: item_stall = 1'b0;
      ST_READ: item_stall = 1'b1;
      ST_CHECK: begin
        if (!pend_v || res_free) begin
          pop       = head_due;
          emit      = pend_v;
          emit_last = !head_due;
        end
      end
      default: item_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ms         <= DELAY_RESET;
      capture_inbound  <= 1'b1;
      capture_outbound <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DELAY:   delay_ms <= (cfg_data > DELAY_MAX) ? DELAY_MAX : cfg_data;
        CFG_CAP_IN:  capture_inbound <= cfg_data[0];
        CFG_CAP_OUT: capture_outbound <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp  <= '0;
      wp  <= '0;
      occ <= '0;
    end else if (accept && (item.mode == MODE_FLUSH)) begin
      rp  <= '0;
      wp  <= '0;
      occ <= '0;
    end else if (wr_en) begin
      wp  <= (wp == PTR_LAST) ? '0 : wp + 1'b1;
      occ <= occ + 1'b1;
    end else if (pop) begin
      rp  <= (rp == PTR_LAST) ? '0 : rp + 1'b1;
      occ <= occ - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_now <= item.now_ms;
    end
  end

  // one-deep hold for the latest result until its last flag is known
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
    end else if (accept && (item.mode == MODE_PACKET) && (!capture || occ == OCC_FULL)) begin
      pend_v <= 1'b1;
    end else if (pop) begin
      pend_v <= 1'b1;
    end else if (emit) begin
      pend_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_tag  <= TAG_FIELD_W'(item.packet_tag[TW-1:0]);
      pend_disp <= capture ? DISP_REFUSED : DISP_PASSED;
    end else if (pop) begin
      pend_tag  <= TAG_FIELD_W'(rd_tag);
      pend_disp <= DISP_RELEASED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= '{tag_out: pend_tag, disposition: pend_disp, last: emit_last};
    end
  end

endmodule

// ===== rtl/tpdq_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpdq_store
// Queue entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tpdq_store #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 48,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/tpdq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpdq_checker
// Port-level checks of the timed packet delay queue, bound to the top level.
// ----------------------------------------------------------------------------
module tpdq_checker
  import tpdq_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      item_valid,
  input logic      item_stall,
  input in_item_t  item,
  input logic      result_valid,
  input logic      result_stall,
  input out_item_t result
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item.mode != MODE_FLUSH) |=> item_stall)
    else $error("new item taken while previous one still in work");

  a_disp_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.disposition == DISP_RELEASED ||
                      result.disposition == DISP_PASSED ||
                      result.disposition == DISP_REFUSED))
    else $error("bad disposition code");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result transfer changed");

endmodule

bind timed_packet_delay_queue tpdq_checker u_tpdq_checker (.*);

// ===== tb/tpdq_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpdq_scoreboard_pkg
// Predicts the released, passed and refused packet tags of the delay queue and
// checks the results that come out of the block against them, in order.
// ----------------------------------------------------------------------------
package tpdq_scoreboard_pkg;
  import tpdq_pkg::*;

  class delay_queue_scoreboard;
    logic [DELAY_W-1:0]     hold_ms;
    bit                     cap_in;
    bit                     cap_out;
    logic [TAG_FIELD_W-1:0] tags[DEF_QUEUE_DEPTH];
    logic [NOW_W-1:0]       release_at[DEF_QUEUE_DEPTH];
    int unsigned            rd;
    int unsigned            wr;
    int unsigned            count;
    out_item_t              expected_q[$];
    int unsigned            errors;
    int unsigned            released;
    int unsigned            passed;
    int unsigned            refused;

    function new();
      errors   = 0;
      released = 0;
      passed   = 0;
      refused  = 0;
      reset();
    endfunction

    function void reset();
      hold_ms = DELAY_RESET;
      cap_in  = 1'b1;
      cap_out = 1'b1;
      rd      = 0;
      wr      = 0;
      count   = 0;
      expected_q.delete();
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DELAY: begin
          hold_ms = (data > DELAY_MAX) ? DELAY_MAX : data;
        end
        CFG_CAP_IN: begin
          cap_in = data[0];
        end
        CFG_CAP_OUT: begin
          cap_out = data[0];
        end
        default: begin
        end
      endcase
    endfunction

    function void push(input logic [TAG_FIELD_W-1:0] tag, input logic [1:0] disp);
      out_item_t r;
      r.tag_out     = tag;
      r.disposition = disp;
      r.last        = 1'b0;
      expected_q.push_back(r);
    endfunction

    // One accepted input transfer: queue, pass or refuse, then drain due heads.
    function void note_item(input in_item_t it);
      int unsigned      first;
      bit               grab;
      logic [NOW_W-1:0] diff;
      first = expected_q.size();
      if (it.mode == MODE_FLUSH) begin
        rd    = 0;
        wr    = 0;
        count = 0;
        return;
      end
      if (it.mode == MODE_PACKET) begin
        grab = it.is_outbound ? cap_out : cap_in;
        if (!grab) begin
          push(it.packet_tag, DISP_PASSED);
        end else if (count >= DEF_QUEUE_DEPTH) begin
          push(it.packet_tag, DISP_REFUSED);
        end else begin
          tags[wr]       = it.packet_tag;
          release_at[wr] = it.now_ms + NOW_W'(hold_ms);
          wr             = (wr + 1) % DEF_QUEUE_DEPTH;
          count++;
        end
      end
      while (count > 0) begin
        diff = it.now_ms - release_at[rd];
        if (diff[NOW_W-1]) break;
        push(tags[rd], DISP_RELEASED);
        rd = (rd + 1) % DEF_QUEUE_DEPTH;
        count--;
      end
      if (expected_q.size() > first) expected_q[expected_q.size()-1].last = 1'b1;
    endfunction

    function void check_result(input out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: tag_out %h disposition %0d last %0d",
               got.tag_out, got.disposition, got.last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.tag_out !== want.tag_out) begin
        $error("tag_out: expected %h, actual %h", want.tag_out, got.tag_out);
        errors++;
      end
      if (got.disposition !== want.disposition) begin
        $error("disposition: expected %0d, actual %0d", want.disposition, got.disposition);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
      case (want.disposition)
        DISP_RELEASED: released++;
        DISP_PASSED:   passed++;
        default:       refused++;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the timed packet delay queue: directed corner cases (signed
// due test across the wrap, zero and saturated delay, pass-through, flush,
// refusal at full queue), then randomized packet streams under several
// register settings with random idling and stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
  import tpdq_pkg::*;
  import tpdq_scoreboard_pkg::*;

  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam int WATCHDOG_LIMIT      = 4000;
  localparam int SETTLE_CYCLES       = 20;
  localparam int HOLD_CYCLES         = 300;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  item_valid;
  logic                  item_stall;
  in_item_t              item;
  logic                  result_valid;
  logic                  result_stall;
  out_item_t             result;

  logic                  hold_request;
  int                    items_sent;
  int                    results_seen;
  int                    settings_used;

  delay_queue_scoreboard sb;

  timed_packet_delay_queue DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // one input transfer; may idle first unless inside the no-idle stretch
  task automatic send_item(input in_item_t it);
    int  gap;
    bit  idle_ok;
    gap     = 0;
    idle_ok = !(items_sent >= 150 && items_sent < 230);
    while (idle_ok && $urandom_range(0, 99) < 29) gap++;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic send_fields(input logic [1:0] mode, input logic [TAG_FIELD_W-1:0] tag,
                             input logic outb, input logic [NOW_W-1:0] now);
    in_item_t it;
    it.mode        = mode;
    it.packet_tag  = tag;
    it.is_outbound = outb;
    it.now_ms      = now;
    send_item(it);
  endtask

  task automatic quiesce();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int delay, input bit cin, input bit cout);
    logic [CFG_DATA_W-1:0] junk;
    logic [CFG_DATA_W-1:0] word;
    quiesce();
    junk = CFG_DATA_W'($urandom());
    word = CFG_DATA_W'(delay);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DELAY;
    cfg_data  <= word;
    @(posedge clk);
    sb.write_reg(CFG_DELAY, word);
    word = {junk[CFG_DATA_W-1:1], cin};
    cfg_index <= CFG_CAP_IN;
    cfg_data  <= word;
    @(posedge clk);
    sb.write_reg(CFG_CAP_IN, word);
    word = {junk[CFG_DATA_W-2:0], cout};
    cfg_index <= CFG_CAP_OUT;
    cfg_data  <= word;
    @(posedge clk);
    sb.write_reg(CFG_CAP_OUT, word);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // packet stream on a running ms clock; hold_at starts the receiver hold-off
  task automatic random_phase(input int n, input int step_max, input logic [NOW_W-1:0] start,
                              input int hold_at);
    logic [NOW_W-1:0] t;
    in_item_t         it;
    int               pick;
    t = start;
    for (int k = 0; k < n; k++) begin
      if (k == hold_at) hold_request <= 1'b1;
      pick           = $urandom_range(0, 99);
      t              = t + NOW_W'($urandom_range(0, step_max));
      it.packet_tag  = TAG_FIELD_W'($urandom());
      it.is_outbound = 1'($urandom_range(0, 1));
      it.now_ms      = t;
      if (pick < 72) begin
        it.mode = MODE_PACKET;
      end else if (pick < 88) begin
        it.mode = MODE_TICK;
      end else if (pick < 92) begin
        it.mode   = MODE_TICK;
        t         = t + NOW_W'($urandom_range(0, 6000));
        it.now_ms = t;
      end else if (pick < 95) begin
        it.mode = MODE_SPARE;
      end else if (pick < 98) begin
        it.mode = MODE_FLUSH;
      end else begin
        it.mode   = 2'($urandom());
        it.now_ms = $urandom();
      end
      send_item(it);
    end
  endtask

  // receiver: checks each result transfer and drives stall
  initial begin
    int hold_left;
    bit hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        sb.check_result(result);
        results_seen++;
      end
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (results_seen >= 200 && results_seen < 280) begin
        result_stall <= 1'b0;
      end else begin
        result_stall <= ($urandom_range(0, 99) < 29);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) quiet = 0;
      else quiet++;
    end
    $display("no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int delay;
    sb            = new();
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = CFG_DELAY;
    cfg_data      = '0;
    item_valid    = 1'b0;
    item          = '0;
    hold_request  = 1'b0;
    items_sent    = 0;
    results_seen  = 0;
    settings_used = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    sb.reset();

    // reset settings: 100 ms, both directions held
    send_fields(MODE_PACKET, 16'h0000, 1'b0, 32'h0000_0000);
    send_fields(MODE_PACKET, 16'hFFFF, 1'b1, 32'h0000_0000);
    send_fields(MODE_TICK,   16'h0000, 1'b0, 32'h8000_0064);
    send_fields(MODE_TICK,   16'hFFFF, 1'b1, 32'h8000_0063);
    send_fields(MODE_PACKET, 16'h1234, 1'b0, 32'hFFFF_FFC0);
    send_fields(MODE_SPARE,  16'h0000, 1'b0, 32'h0000_0023);
    send_fields(MODE_SPARE,  16'hFFFF, 1'b1, 32'h0000_0024);
    send_fields(MODE_PACKET, 16'h4321, 1'b1, 32'h0000_0005);
    send_fields(MODE_FLUSH,  16'h0000, 1'b0, 32'h0000_00C8);
    // zero delay, inbound passes through
    set_config(0, 1'b0, 1'b1);
    send_fields(MODE_PACKET, 16'hA5A5, 1'b0, 32'h0000_0007);
    send_fields(MODE_PACKET, 16'h5A5A, 1'b1, 32'h8000_0000);
    // delay above range saturates, outbound passes through
    set_config(8191, 1'b1, 1'b0);
    send_fields(MODE_PACKET, 16'h0F0F, 1'b1, 32'h0000_0009);
    send_fields(MODE_PACKET, 16'hF0F0, 1'b0, 32'd1000);
    send_fields(MODE_TICK,   16'h0000, 1'b0, 32'd6000);
    // fill the queue, refuse, then refuse again on the item that drains all
    set_config(5000, 1'b1, 1'b1);
    for (int k = 0; k < DEF_QUEUE_DEPTH; k++)
      send_fields(MODE_PACKET, TAG_FIELD_W'(k * 2053), k[0], 32'd10);
    send_fields(MODE_PACKET, 16'hBEEF, 1'b0, 32'd10);
    send_fields(MODE_PACKET, 16'hCAFE, 1'b1, 32'd5010);

    set_config(0, 1'b1, 1'b1);
    random_phase(60, 3, $urandom(), -1);
    set_config(20, 1'b1, 1'b1);
    random_phase(80, 6, 32'hFFFF_FF00, 20);
    set_config(5000, 1'b0, 1'b1);
    random_phase(60, 700, $urandom(), -1);
    set_config(37, 1'b1, 1'b0);
    random_phase(90, 2, $urandom(), -1);
    set_config(1, 1'b0, 1'b0);
    random_phase(40, 3, $urandom(), -1);
    delay = $urandom_range(1, 300);
    set_config(delay, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    random_phase(80, delay / 6 + 1, $urandom(), -1);
    quiesce();

    $display("Covered %0d transfers under %0d register settings: %0d released, %0d passed,",
             items_sent, settings_used, sb.released, sb.passed);
    $display("%0d refused, %0d mismatches.", sb.refused, sb.errors);
    if (sb.pending() != 0) $error("%0d expected results never arrived", sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tpdq_pkg.sv
rtl/tpdq_store.sv
rtl/timed_packet_delay_queue.sv
rtl/tpdq_checker.sv
tb/tpdq_scoreboard_pkg.sv
tb/tb.sv
